>>> rtl/psg_pkg.sv
// ---------------------------------------------------------------------------
// psg_pkg: shared types and constants
// Widths, limits and the result word layout of the prime sieve generator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psg_pkg;

    localparam int MAX_LIMIT   = 255;
    localparam int STORE_DEPTH = 256;
    localparam int MAX_OUT     = 64;

    localparam int LIMIT_W = 8;
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int CAND_W  = ADDR_W + 1;
    localparam int MULT_W  = ADDR_W + 2;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;

    // effective top of the sieve: the limit saturates here
    localparam int MAX_N_INT = (MAX_LIMIT < STORE_DEPTH - 1) ? MAX_LIMIT : STORE_DEPTH - 1;
    localparam logic [CAND_W-1:0] MAX_N = CAND_W'(MAX_N_INT);

    typedef struct packed {
        logic [LIMIT_W-1:0] prime_value;
        logic [INDEX_W-1:0] prime_index;
        logic               has_prime;
        logic [COUNT_W-1:0] prime_count;
        logic               last_of_run;
    } rsp_word_t;

    // handoff from the sequencer to the output stage
    typedef struct packed {
        logic      push;
        rsp_word_t word;
    } push_t;

endpackage

`default_nettype wire

>>> rtl/psg_if.sv
// ---------------------------------------------------------------------------
// psg_if: request and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface psg_req_if;
    logic                          valid;
    logic                          ready;
    logic [psg_pkg::LIMIT_W-1:0]   limit;

    modport source (output valid, output limit, input ready);
    modport sink   (input valid, input limit, output ready);
endinterface

interface psg_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [psg_pkg::LIMIT_W-1:0]   prime_value;
    logic [psg_pkg::INDEX_W-1:0]   prime_index;
    logic                          has_prime;
    logic [psg_pkg::COUNT_W-1:0]   prime_count;
    logic                          last_of_run;

    modport source (output valid, output prime_value, output prime_index,
                    output has_prime, output prime_count, output last_of_run,
                    input ready);
    modport sink   (input valid, input prime_value, input prime_index,
                    input has_prime, input prime_count, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/psg_ram.sv
// ---------------------------------------------------------------------------
// psg_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psg_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/psg_ctrl.sv
// ---------------------------------------------------------------------------
// psg_ctrl: sieve sequencer
// Clears the mark store, tests candidates and strikes multiples; holds the
// newest prime back one step so the final word can carry last and count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psg_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    psg_req_if.sink                        req,
    input  wire logic                      push_ok,
    output      psg_pkg::push_t            push_out,
    output      logic                      mem_we,
    output      logic [psg_pkg::ADDR_W-1:0] mem_waddr,
    output      logic                      mem_wdata,
    output      logic                      mem_re,
    output      logic [psg_pkg::ADDR_W-1:0] mem_raddr,
    input  wire logic                      mem_rdata
);
    import psg_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_STRIKE = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;
    localparam logic [2:0] ST_EMPTY  = 3'd6;

    logic [2:0]         state_reg,      state_next;
    logic [ADDR_W-1:0]  n_reg,          n_next;
    logic [CAND_W-1:0]  cand_reg,       cand_next;
    logic [MULT_W-1:0]  mult_reg,       mult_next;
    logic [COUNT_W-1:0] found_reg,      found_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [LIMIT_W-1:0] pend_value_reg, pend_value_next;
    logic [INDEX_W-1:0] pend_index_reg, pend_index_next;

    logic [ADDR_W-1:0]  limit_sat;
    logic               cand_at_n;

    assign limit_sat = (CAND_W'(req.limit) > MAX_N) ? MAX_N[ADDR_W-1:0] : req.limit;
    assign cand_at_n = (cand_reg == CAND_W'(n_reg));
    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        cand_next       = cand_reg;
        mult_next       = mult_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        pend_index_next = pend_index_reg;
        push_out        = '0;
        mem_we          = 1'b0;
        mem_waddr       = cand_reg[ADDR_W-1:0];
        mem_wdata       = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = cand_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    n_next          = limit_sat;
                    found_next      = '0;
                    pend_valid_next = 1'b0;
                    cand_next       = CAND_W'(2);
                    state_next      = (limit_sat < ADDR_W'(2)) ? ST_EMPTY : ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (cand_at_n)
                begin
                    cand_next  = CAND_W'(2);
                    state_next = ST_READ;
                end
                else
                begin
                    cand_next = cand_reg + CAND_W'(1);
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (mem_rdata)
                begin
                    // composite: next candidate
                    if (cand_at_n)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cand_next  = cand_reg + CAND_W'(1);
                        state_next = ST_READ;
                    end
                end
                else if (found_reg < COUNT_W'(MAX_OUT))
                begin
                    if (!pend_valid_reg || push_ok)
                    begin
                        push_out.push             = pend_valid_reg;
                        push_out.word.prime_value = pend_value_reg;
                        push_out.word.prime_index = pend_index_reg;
                        push_out.word.has_prime   = 1'b1;
                        pend_valid_next = 1'b1;
                        pend_value_next = cand_reg[LIMIT_W-1:0];
                        pend_index_next = found_reg[INDEX_W-1:0];
                        found_next      = found_reg + COUNT_W'(1);
                        mult_next       = {cand_reg, 1'b0};
                        state_next      = ST_STRIKE;
                    end
                end
                else
                begin
                    mult_next  = {cand_reg, 1'b0};
                    state_next = ST_STRIKE;
                end
            end
            ST_STRIKE:
            begin
                if (mult_reg <= MULT_W'(n_reg))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = mult_reg[ADDR_W-1:0];
                    mem_wdata = 1'b1;
                    mult_next = mult_reg + MULT_W'(cand_reg);
                end
                else if (cand_at_n)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cand_next  = cand_reg + CAND_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_FINISH:
            begin
                if (push_ok)
                begin
                    push_out.push             = 1'b1;
                    push_out.word.prime_value = pend_value_reg;
                    push_out.word.prime_index = pend_index_reg;
                    push_out.word.has_prime   = 1'b1;
                    push_out.word.prime_count = found_reg;
                    push_out.word.last_of_run = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                if (push_ok)
                begin
                    push_out.push             = 1'b1;
                    push_out.word.last_of_run = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cand_reg       <= '0;
            mult_reg       <= '0;
            found_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cand_reg       <= cand_next;
            mult_reg       <= mult_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        pend_value_reg <= pend_value_next;
        pend_index_reg <= pend_index_next;
    end

endmodule

`default_nettype wire

>>> rtl/psg_out_stage.sv
// ---------------------------------------------------------------------------
// psg_out_stage: result output register
// Holds one result word until the sink takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psg_out_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire psg_pkg::push_t push_in,
    output      logic           push_ok,
    psg_rsp_if.source           rsp
);
    import psg_pkg::*;

    logic      valid_reg, valid_next;
    rsp_word_t word_reg,  word_next;

    assign push_ok = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg && !rsp.ready;
        word_next  = word_reg;
        if (push_in.push)
        begin
            valid_next = 1'b1;
            word_next  = push_in.word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign rsp.valid       = valid_reg;
    assign rsp.prime_value = word_reg.prime_value;
    assign rsp.prime_index = word_reg.prime_index;
    assign rsp.has_prime   = word_reg.has_prime;
    assign rsp.prime_count = word_reg.prime_count;
    assign rsp.last_of_run = word_reg.last_of_run;

endmodule

`default_nettype wire

>>> rtl/prime_sieve_generator_unit.sv
// ---------------------------------------------------------------------------
// prime_sieve_generator_unit: sieve of Eratosthenes prime generator
// Takes a limit word and returns every prime up to it, one word per prime.
// ---------------------------------------------------------------------------
// Each request word carries a limit n, saturated to MAX_LIMIT. The block
// answers with one result word per prime from 2 to n in ascending order,
// each with its position in the list; the final word has last_of_run set and
// carries the total count (prime_count is zero on every other word). For n
// below two the answer is a single word with has_prime, value, index and
// count all zero and last_of_run set. One request is worked on at a time:
// req.ready is high only while the sieve is idle. A request is accepted,
// then the 256x1 mark RAM is cleared from 2 to n; each candidate is read
// from the RAM and then tested, and each prime strikes its multiples one
// write at a time (about n ln ln n strikes in all) before the scan moves
// on; after the scan the last word is sent. The single write port of the
// mark RAM paces the clearing and the strikes. A stalled result sink
// stretches a request further, since a new prime waits until the output
// register is free.
`timescale 1ns / 1ps
`default_nettype none

module prime_sieve_generator_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    psg_req_if.sink   req,
    psg_rsp_if.source rsp
);
    import psg_pkg::*;

    // sequencer <-> mark RAM
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              mem_rdata;

    // sequencer <-> output register
    push_t             push;
    logic              push_ok;

    // one mark bit per value; a set bit means "known composite"
    psg_ram #(
        .WIDTH (1),
        .DEPTH (STORE_DEPTH)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // clear, test and strike sequencer; keeps the newest prime pending so
    // the last word can be tagged once the scan reaches n
    psg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .push_ok   (push_ok),
        .push_out  (push),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // result register toward the sink
    psg_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (push),
        .push_ok (push_ok),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

>>> tb/prime_sieve_generator_unit_test.sv
// ---------------------------------------------------------------------------
// prime_sieve_generator_unit_test: self-checking bench for the prime sieve
// Sends limit words and checks every returned prime word against a local
// sieve, with random gaps on the request side and random stalls on results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_sieve_generator_unit_test;

    import psg_pkg::*;

    // no accept on either channel for this long means the block is stuck
    localparam int IDLE_LIMIT  = 20000;
    localparam int RAND_ITEMS  = 300;
    localparam int DRAIN_WAIT  = 64;
    localparam int DIR_ROWS    = 21;

    // directed row: a limit, and for runs that give a single result word,
    // that expected word typed in
    typedef struct {
        logic [LIMIT_W-1:0] limit;
        bit                 typed;
        rsp_word_t          word;
    } dir_row_t;

    localparam rsp_word_t EMPTY_RUN = '{prime_value: '0, prime_index: '0, has_prime: 1'b0,
                                        prime_count: '0, last_of_run: 1'b1};
    localparam rsp_word_t ONLY_TWO  = '{prime_value: 8'd2, prime_index: '0, has_prime: 1'b1,
                                        prime_count: 7'd1, last_of_run: 1'b1};
    localparam rsp_word_t NO_WORD   = '0;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sink_ready = 1'b0;

    psg_req_if req_ch ();
    psg_rsp_if rsp_ch ();

    assign rsp_ch.ready = sink_ready;

    prime_sieve_generator_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // words still owed by the block, oldest first
    rsp_word_t primes_due [$];

    int  fails;
    int  limits_sent;
    int  words_checked;
    int  empty_runs;
    int  full_runs;
    int  idle_cycles;
    int  hold_cnt;
    bit  calm;          // when set, neither side inserts gaps

    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        '{8'd0,   1'b1, EMPTY_RUN},     // empty run, all-zero limit
        '{8'd1,   1'b1, EMPTY_RUN},     // empty run, just below two
        '{8'd2,   1'b1, ONLY_TWO},      // smallest non-empty run
        '{8'd3,   1'b0, NO_WORD},
        '{8'd4,   1'b0, NO_WORD},
        '{8'd5,   1'b0, NO_WORD},
        '{8'd7,   1'b0, NO_WORD},
        '{8'd8,   1'b0, NO_WORD},
        '{8'd11,  1'b0, NO_WORD},
        '{8'd12,  1'b0, NO_WORD},
        '{8'd49,  1'b0, NO_WORD},       // square of a prime at the top
        '{8'd85,  1'b0, NO_WORD},       // alternating bit patterns
        '{8'd170, 1'b0, NO_WORD},
        '{8'd127, 1'b0, NO_WORD},
        '{8'd128, 1'b0, NO_WORD},
        '{8'd251, 1'b0, NO_WORD},       // largest prime that fits
        '{8'd254, 1'b0, NO_WORD},
        '{8'd255, 1'b0, NO_WORD},       // full sieve, all-ones limit
        '{8'd1,   1'b1, EMPTY_RUN},     // empty run right after a full one
        '{8'd255, 1'b0, NO_WORD},
        '{8'd2,   1'b1, ONLY_TWO}
    };

    // Sieve the limit and queue one word per prime in ascending order.
    // The limit saturates at the top of the store; the count lands only on
    // the last word and stops at MAX_OUT, as does the number of words.
    function automatic void sieve_limit(input logic [LIMIT_W-1:0] limit);
        bit        struck [0:STORE_DEPTH-1];
        rsp_word_t run_q [$];
        rsp_word_t w;
        int        top;
        int        found;
        top   = (int'(limit) > MAX_N_INT) ? MAX_N_INT : int'(limit);
        found = 0;
        if (top < 2)
        begin
            primes_due.push_back(EMPTY_RUN);
            return;
        end
        for (int c = 2; c <= top; c++)
        begin
            if (!struck[c])
            begin
                struck[c] = 1'b1;
                if (found < MAX_OUT)
                begin
                    w             = '0;
                    w.prime_value = LIMIT_W'(c);
                    w.prime_index = INDEX_W'(found);
                    w.has_prime   = 1'b1;
                    run_q.push_back(w);
                    found++;
                end
                for (int m = 2 * c; m <= top; m += c)
                    struck[m] = 1'b1;
            end
        end
        w             = run_q.pop_back();
        w.prime_count = COUNT_W'(found);
        w.last_of_run = 1'b1;
        run_q.push_back(w);
        foreach (run_q[i])
            primes_due.push_back(run_q[i]);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    // Present one limit after a gap of idle cycles and wait for acceptance.
    // Entered right after an edge; valid gets exactly one update per edge.
    task automatic send_limit(input logic [LIMIT_W-1:0] limit, input bit typed,
                              input rsp_word_t word);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            req_ch.limit <= LIMIT_W'($urandom);   // noise while idle
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.limit <= limit;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // accepted at this edge
        if (typed)
            primes_due.push_back(word);
        else
            sieve_limit(limit);
        limits_sent++;
    endtask

    function automatic logic [LIMIT_W-1:0] draw_limit();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 5)
            return LIMIT_W'($urandom_range(0, 255));
        if (pick <= 8)
            return LIMIT_W'($urandom_range(0, 20));     // short, cheap runs
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // Result side: check each accepted word against the oldest one owed,
    // then draw a fresh stall for the next word.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t due;
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
            hold_cnt = 0;
        end
        else
        begin
            if (rsp_ch.valid && sink_ready)
            begin
                words_checked++;
                if (primes_due.size() == 0)
                begin
                    $error("result word with nothing pending: value %0d index %0d",
                           rsp_ch.prime_value, rsp_ch.prime_index);
                    fails++;
                end
                else
                begin
                    due = primes_due.pop_front();
                    check_field("prime_value", due.prime_value, rsp_ch.prime_value);
                    check_field("prime_index", due.prime_index, rsp_ch.prime_index);
                    check_field("has_prime",   due.has_prime,   rsp_ch.has_prime);
                    check_field("prime_count", due.prime_count, rsp_ch.prime_count);
                    check_field("last_of_run", due.last_of_run, rsp_ch.last_of_run);
                    if (due.last_of_run && !due.has_prime)
                        empty_runs++;
                    if (due.last_of_run && due.prime_value == 8'd251)
                        full_runs++;
                end
                hold_cnt = calm ? 0 : $urandom_range(0, 9);
            end
            else if (hold_cnt > 0)
                hold_cnt--;
            sink_ready <= (hold_cnt == 0);
        end
    end

    // Watchdog: count cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: %0d words still pending", primes_due.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.limit = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, back to back with gaps as drawn
        foreach (dir_tab[i])
            send_limit(dir_tab[i].limit, dir_tab[i].typed, dir_tab[i].word);

        // random part; every third block of 40 runs without any idling
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            calm = ((i / 40) % 3) == 2;
            send_limit(draw_limit(), 1'b0, NO_WORD);
        end
        calm = 1'b0;
        req_ch.valid <= 1'b0;

        while (primes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d limits sent (%0d directed), %0d result words checked",
                 limits_sent, DIR_ROWS, words_checked);
        $display("%0d empty runs, %0d runs over the full sieve", empty_runs, full_runs);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/psg_pkg.sv
rtl/psg_if.sv
rtl/psg_ram.sv
rtl/psg_ctrl.sv
rtl/psg_out_stage.sv
rtl/prime_sieve_generator_unit.sv
tb/prime_sieve_generator_unit_test.sv
